>>> hdl/text_console_writer_core_macros.svh
// ============================================================================
// text_console_writer_core_macros.svh
// Assertion macros for the text console writer, empty in synthesis builds.
// ============================================================================
`ifndef TEXT_CONSOLE_WRITER_CORE_MACROS_SVH
`define TEXT_CONSOLE_WRITER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge of i_clk outside reset.
`define TCW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define TCW_NEVER(lbl, cond, msg) \
    `TCW_ASSERT(lbl, !(cond), msg)

`else

`define TCW_ASSERT(lbl, prop, msg)
`define TCW_NEVER(lbl, cond, msg)

`endif

`endif

>>> hdl/tcw_pkg.sv
// ============================================================================
// tcw_pkg
// Screen geometry, character codes, action codes and shared types.
// ============================================================================
package tcw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;
    localparam int ADDR_W  = $clog2(CELLS);
    localparam int COL_W   = $clog2(COLUMNS);
    localparam int ROW_W   = $clog2(ROWS);
    localparam int CELL_W  = 16;

    localparam logic [7:0] NEWLINE_CODE   = 8'h0A;
    localparam logic [7:0] BLANK_CODE     = 8'h20;
    localparam logic [7:0] MARKER_CODE    = 8'h45;
    localparam logic [7:0] CLEAR_ATTR_RST = 8'd7;
    localparam logic [7:0] ERROR_ATTR_RST = 8'd4;

    localparam logic [1:0] ACT_PUT   = 2'd0;
    localparam logic [1:0] ACT_CLEAR = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    localparam logic REG_CLEAR_ATTR = 1'b0;
    localparam logic REG_ERROR_ATTR = 1'b1;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_FILL,
        ST_CLEAR,
        ST_HOLD
    } t_state;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             err;
        logic [7:0]       rc;
        logic [7:0]       ra;
    } t_result;

endpackage

>>> hdl/tcw_ram.sv
// ============================================================================
// tcw_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ============================================================================
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/text_console_writer_core.sv
// ============================================================================
// text_console_writer_core
// Text-mode console: put, clear and read cells of a screen held in one RAM.
// ============================================================================
// Put: the result is registered, or parked in the pending slot while the output
//   stalls, and new items then wait. Put with scroll: one cell moved a cycle
//   through the single RAM write port. Read: via the registered RAM read. Clear:
//   a blanking sweep. Reset: a sweep over all CELLS cells (2000 at 80x25) writes ' ' with
//   attribute 7 to every cell; input items stall, config writes are taken.
// ============================================================================
module text_console_writer_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input item channel
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [1:0]                 i_action,
    input  logic                       i_use_cursor,
    input  logic [7:0]                 i_column,
    input  logic [7:0]                 i_row,
    input  logic [7:0]                 i_char_code,
    input  logic [7:0]                 i_attribute,
    // result channel
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [6:0]                 o_cursor_column,
    output logic [4:0]                 o_cursor_row,
    output logic                       o_error,
    output logic [7:0]                 o_read_char,
    output logic [7:0]                 o_read_attr,
    // configuration port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    import tcw_pkg::*;

    `include "text_console_writer_core_macros.svh"

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    logic [7:0] r_clear_attr;
    logic [7:0] r_err_attr;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clear_attr <= CLEAR_ATTR_RST;
            r_err_attr   <= ERROR_ATTR_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_CLEAR_ATTR) begin
                r_clear_attr <= pwdata[7:0];
            end else begin
                r_err_attr <= pwdata[7:0];
            end
        end
    end

    // Word-aligned decode on bit 2; upper data bits read as zero.
    assign prdata = {24'd0, (paddr[2] == REG_CLEAR_ATTR) ? r_clear_attr : r_err_attr};

    // ------------------------------------------------------------------------
    // Screen memory: one cell per word, character in the high byte
    // ------------------------------------------------------------------------
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------------
    t_state            r_state,   n_state;
    logic [ADDR_W-1:0] r_cnt,     n_cnt;       // sweep / scroll cell index
    logic [COL_W-1:0]  r_cur_col, n_cur_col;   // cursor kept as column and row
    logic [ROW_W-1:0]  r_cur_row, n_cur_row;
    logic              r_o_valid, n_o_valid;
    t_result           r_o;                    // output register
    t_result           r_pend;                 // result waiting behind r_o

    // ------------------------------------------------------------------------
    // Decode of the offered item
    // ------------------------------------------------------------------------
    logic              outside;
    logic [7:0]        sel_col;
    logic [7:0]        sel_row;
    logic [ADDR_W-1:0] in_pos;
    logic              is_newline;
    logic              col_last;
    logic              row_last;
    logic              adv_row;
    logic              scroll;
    logic [COL_W-1:0]  put_col;
    logic [ROW_W-1:0]  put_row;

    assign outside  = !i_use_cursor &&
                      ((i_column >= 8'(COLUMNS)) || (i_row >= 8'(ROWS)));
    assign sel_col  = i_use_cursor ? 8'(r_cur_col) : i_column;
    assign sel_row  = i_use_cursor ? 8'(r_cur_row) : i_row;
    assign in_pos   = ADDR_W'({8'd0, sel_row} * 16'(COLUMNS) + {8'd0, sel_col});

    // A newline or a put in the last column moves to the next row; moving
    // off the bottom row scrolls and keeps the cursor on the bottom row.
    assign is_newline = (i_char_code == NEWLINE_CODE);
    assign col_last   = (sel_col == 8'(COLUMNS - 1));
    assign row_last   = (sel_row == 8'(ROWS - 1));
    assign adv_row    = is_newline || col_last;
    assign scroll     = adv_row && row_last;
    assign put_col    = adv_row ? '0 : COL_W'(sel_col + 8'd1);
    assign put_row    = !adv_row ? ROW_W'(sel_row) :
                        row_last ? ROW_W'(ROWS - 1) : ROW_W'(sel_row + 8'd1);

    // ------------------------------------------------------------------------
    // Next state and outputs
    // ------------------------------------------------------------------------
    logic    done;
    logic    out_free;
    t_result res;

    assign out_free = !r_o_valid || !i_out_stall;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_cur_col  = r_cur_col;
        n_cur_row  = r_cur_row;
        ram_we     = 1'b0;
        ram_waddr  = r_cnt;
        ram_wdata  = '0;
        ram_re     = 1'b0;
        ram_raddr  = in_pos;
        done       = 1'b0;
        res        = '0;
        o_in_stall = 1'b1;

        case (r_state)
            ST_INIT, ST_CLEAR: begin
                // Blank one cell a cycle; the reset sweep ignores config.
                ram_we    = 1'b1;
                ram_wdata = {BLANK_CODE,
                             (r_state == ST_INIT) ? CLEAR_ATTR_RST : r_clear_attr};
                if (r_cnt == ADDR_W'(CELLS - 1)) begin
                    n_cnt = '0;
                    if (r_state == ST_INIT) begin
                        n_state = ST_IDLE;
                    end else begin
                        done = 1'b1;
                    end
                end else begin
                    n_cnt = r_cnt + ADDR_W'(1);
                end
            end

            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    case (i_action)
                        ACT_PUT: begin
                            if (outside) begin
                                // Drop the item, flag it in the last cell.
                                ram_we    = 1'b1;
                                ram_waddr = ADDR_W'(CELLS - 1);
                                ram_wdata = {MARKER_CODE, r_err_attr};
                                res.err   = 1'b1;
                                done      = 1'b1;
                            end else begin
                                ram_we    = !is_newline;
                                ram_waddr = in_pos;
                                ram_wdata = {i_char_code, i_attribute};
                                n_cur_col = put_col;
                                n_cur_row = put_row;
                                if (scroll) begin
                                    n_cnt   = '0;
                                    n_state = ST_SCROLL;
                                end else begin
                                    done = 1'b1;
                                end
                            end
                        end
                        ACT_CLEAR: begin
                            n_cur_col = '0;
                            n_cur_row = '0;
                            n_cnt     = '0;
                            n_state   = ST_CLEAR;
                        end
                        ACT_READ: begin
                            if (outside) begin
                                res.err = 1'b1;
                                done    = 1'b1;
                            end else begin
                                ram_re  = 1'b1;
                                n_state = ST_READ;
                            end
                        end
                        default: begin
                            done = 1'b1;
                        end
                    endcase
                end
            end

            ST_READ: begin
                res.rc = ram_rdata[15:8];
                res.ra = ram_rdata[7:0];
                done   = 1'b1;
            end

            ST_SCROLL: begin
                // Read cell cnt+COLUMNS while writing the word read last
                // cycle into cell cnt-1: the copy runs one cell behind.
                ram_re    = (r_cnt < ADDR_W'(CELLS - COLUMNS));
                ram_raddr = ADDR_W'(r_cnt + ADDR_W'(COLUMNS));
                ram_we    = (r_cnt != '0);
                ram_waddr = r_cnt - ADDR_W'(1);
                ram_wdata = ram_rdata;
                if (r_cnt == ADDR_W'(CELLS - COLUMNS)) begin
                    n_state = ST_FILL;
                end else begin
                    n_cnt = r_cnt + ADDR_W'(1);
                end
            end

            ST_FILL: begin
                // Zero the bottom row.
                ram_we    = 1'b1;
                ram_wdata = '0;
                if (r_cnt == ADDR_W'(CELLS - 1)) begin
                    n_cnt = '0;
                    done  = 1'b1;
                end else begin
                    n_cnt = r_cnt + ADDR_W'(1);
                end
            end

            ST_HOLD: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase

        res.col = n_cur_col;
        res.row = n_cur_row;

        // Park a finished result when the output register is still taken.
        if (done) begin
            n_state = out_free ? ST_IDLE : ST_HOLD;
        end
    end

    // ------------------------------------------------------------------------
    // Output register and pending slot
    // ------------------------------------------------------------------------
    logic load_res;
    logic load_pend;

    assign load_res  = done && out_free;
    assign load_pend = (r_state == ST_HOLD) && out_free;
    assign n_o_valid = load_res || load_pend || (r_o_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_INIT;
            r_cnt     <= '0;
            r_cur_col <= '0;
            r_cur_row <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_cur_col <= n_cur_col;
            r_cur_row <= n_cur_row;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_res) begin
            r_o <= res;
        end else if (load_pend) begin
            r_o <= r_pend;
        end
        if (done && !out_free) begin
            r_pend <= res;
        end
    end

    assign o_out_valid     = r_o_valid;
    assign o_cursor_column = 7'(r_o.col);
    assign o_cursor_row    = 5'(r_o.row);
    assign o_error         = r_o.err;
    assign o_read_char     = r_o.rc;
    assign o_read_attr     = r_o.ra;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `TCW_ASSERT(a_cursor_on_screen,
        (r_cur_col < COL_W'(COLUMNS)) && (r_cur_row < ROW_W'(ROWS)),
        "cursor left the screen")
    `TCW_ASSERT(a_hold_behind_full_output, (r_state == ST_HOLD) |-> r_o_valid,
        "pending result parked while the output register is empty")
    `TCW_NEVER(a_write_in_range, ram_we && (ram_waddr >= ADDR_W'(CELLS)),
        "screen write beyond the last cell")
    `TCW_ASSERT(a_read_follows,
        (r_state == ST_IDLE && i_in_valid && i_action == ACT_READ && !outside)
            |=> (r_state == ST_READ),
        "accepted read did not wait for RAM data")

endmodule

>>> dv/tcw_console_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// tcw_console_checker
// Watches the word channels and the register port of the text console,
// keeps its own copy of the screen, cursor and registers, and compares
// every reply with the oldest prediction.
// ============================================================================
module tcw_console_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_action,
    input  logic        i_use_cursor,
    input  logic [7:0]  i_column,
    input  logic [7:0]  i_row,
    input  logic [7:0]  i_char_code,
    input  logic [7:0]  i_attribute,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [6:0]  i_cursor_column,
    input  logic [4:0]  i_cursor_row,
    input  logic        i_error,
    input  logic [7:0]  i_read_char,
    input  logic [7:0]  i_read_attr,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_fail_count,
    output int          o_pending
);
    import tcw_pkg::*;

    logic [7:0] screen_char [CELLS];
    logic [7:0] screen_attr [CELLS];
    int         cursor_idx;
    logic [7:0] blank_attr;
    logic [7:0] marker_attr;
    t_result    console_replies [$];
    int         fail_total;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        fail_total   = 0;
    end

    function automatic void blank_screen();
        for (int i = 0; i < CELLS; i++) begin
            screen_char[i] = BLANK_CODE;
            screen_attr[i] = blank_attr;
        end
    endfunction

    // Update the screen copy for one word and return the reply it causes.
    function automatic t_result apply_console_action(input logic [1:0] act,
                                                     input logic       at_cursor,
                                                     input logic [7:0] col,
                                                     input logic [7:0] row,
                                                     input logic [7:0] ch,
                                                     input logic [7:0] attr);
        t_result reply;
        logic    off_screen;
        int      pos;
        reply      = '0;
        off_screen = !at_cursor && (int'(col) >= COLUMNS || int'(row) >= ROWS);
        pos        = at_cursor ? cursor_idx : int'(row) * COLUMNS + int'(col);
        case (act)
            ACT_PUT: begin
                if (off_screen) begin
                    screen_char[CELLS-1] = MARKER_CODE;
                    screen_attr[CELLS-1] = marker_attr;
                    reply.err = 1'b1;
                end else begin
                    if (pos >= CELLS)
                        pos = 0;
                    if (ch == NEWLINE_CODE) begin
                        pos = (pos / COLUMNS + 1) * COLUMNS;
                    end else begin
                        screen_char[pos] = ch;
                        screen_attr[pos] = attr;
                        pos++;
                    end
                    // past the last cell: scroll up, zero the bottom row
                    if (pos >= CELLS) begin
                        for (int i = 0; i < CELLS - COLUMNS; i++) begin
                            screen_char[i] = screen_char[i+COLUMNS];
                            screen_attr[i] = screen_attr[i+COLUMNS];
                        end
                        for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
                            screen_char[i] = 8'h00;
                            screen_attr[i] = 8'h00;
                        end
                        pos -= COLUMNS;
                    end
                    cursor_idx = pos;
                end
            end
            ACT_CLEAR: begin
                blank_screen();
                cursor_idx = 0;
            end
            ACT_READ: begin
                if (off_screen) begin
                    reply.err = 1'b1;
                end else if (pos < CELLS) begin
                    reply.rc = screen_char[pos];
                    reply.ra = screen_attr[pos];
                end
            end
            default: ;
        endcase
        reply.col = COL_W'(cursor_idx % COLUMNS);
        reply.row = ROW_W'(cursor_idx / COLUMNS);
        return reply;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            blank_attr  = CLEAR_ATTR_RST;
            marker_attr = ERROR_ATTR_RST;
            cursor_idx  = 0;
            blank_screen();
            console_replies.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
                case (paddr[2])
                    REG_CLEAR_ATTR: blank_attr  = pwdata[7:0];
                    REG_ERROR_ATTR: marker_attr = pwdata[7:0];
                    default: ;
                endcase
            end
            // compare the reply before taking a new word
            if (i_out_valid && !i_out_stall) begin
                got.col = i_cursor_column;
                got.row = i_cursor_row;
                got.err = i_error;
                got.rc  = i_read_char;
                got.ra  = i_read_attr;
                if (console_replies.size() == 0) begin
                    fail_total++;
                    if (fail_total <= 10)
                        $display("unexpected reply: col %0d row %0d err %0b char %h attr %h",
                                 got.col, got.row, got.err, got.rc, got.ra);
                end else begin
                    want = console_replies.pop_front();
                    if (got.col != want.col || got.row != want.row ||
                        got.err != want.err || got.rc != want.rc || got.ra != want.ra) begin
                        fail_total++;
                        if (fail_total <= 10)
                            $display("reply mismatch: exp col %0d row %0d err %0b char %h attr %h, got col %0d row %0d err %0b char %h attr %h",
                                     want.col, want.row, want.err, want.rc, want.ra,
                                     got.col, got.row, got.err, got.rc, got.ra);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                want = apply_console_action(i_action, i_use_cursor, i_column, i_row,
                                            i_char_code, i_attribute);
                console_replies.push_back(want);
            end
        end
        o_pending    <= console_replies.size();
        o_fail_count <= fail_total;
    end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Drives words and register writes into the text console and gives the
// verdict; the checker beside the block predicts and compares the replies.
// ============================================================================
module tb_top;
    import tcw_pkg::*;

    // Action code 3 is unused by the block: it must change nothing.
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    // Worst case: every word scrolls, plus long stalls and gaps.
    localparam int CYCLE_LIMIT  = 10_000_000;
    localparam int SETTLE       = 8;
    localparam int PHASES       = 4;
    localparam int PHASE_WORDS  = 263;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_action     = ACT_PUT;
    logic        i_use_cursor = 1'b0;
    logic [7:0]  i_column     = 8'h00;
    logic [7:0]  i_row        = 8'h00;
    logic [7:0]  i_char_code  = 8'h00;
    logic [7:0]  i_attribute  = 8'h00;
    logic        o_out_valid;
    logic        i_out_stall  = 1'b0;
    logic [6:0]  o_cursor_column;
    logic [4:0]  o_cursor_row;
    logic        o_error;
    logic [7:0]  o_read_char;
    logic [7:0]  o_read_attr;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [2:0]  paddr        = 3'd0;
    logic [31:0] pwdata       = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          replies_due;
    int unsigned idle_pct  = 0;
    int unsigned stall_pct = 0;
    // last explicit put position, so reads land on written cells
    logic [7:0]  last_col  = 8'h00;
    logic [7:0]  last_row  = 8'h00;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    text_console_writer_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_action       (i_action),
        .i_use_cursor   (i_use_cursor),
        .i_column       (i_column),
        .i_row          (i_row),
        .i_char_code    (i_char_code),
        .i_attribute    (i_attribute),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_cursor_column(o_cursor_column),
        .o_cursor_row   (o_cursor_row),
        .o_error        (o_error),
        .o_read_char    (o_read_char),
        .o_read_attr    (o_read_attr),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    tcw_console_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_action       (i_action),
        .i_use_cursor   (i_use_cursor),
        .i_column       (i_column),
        .i_row          (i_row),
        .i_char_code    (i_char_code),
        .i_attribute    (i_attribute),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_cursor_column(o_cursor_column),
        .i_cursor_row   (o_cursor_row),
        .i_error        (o_error),
        .i_read_char    (o_read_char),
        .i_read_attr    (o_read_attr),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .o_fail_count   (fail_count),
        .o_pending      (replies_due)
    );

    // Receiver side: stall the reply channel at the rate of the phase.
    always @(posedge i_clk)
        i_out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);

    // Hard stop in case the block hangs or drops a reply.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("status: fail");
        $finish;
    end

    // Offer one word and hold it until the block takes it. An optional gap
    // drops valid first; valid is never lowered and raised in the same step.
    task automatic send_word(input logic [1:0] act, input logic at_cursor,
                             input logic [7:0] col, input logic [7:0] row,
                             input logic [7:0] ch, input logic [7:0] attr);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < idle_pct);
        end
        i_in_valid   <= 1'b1;
        i_action     <= act;
        i_use_cursor <= at_cursor;
        i_column     <= col;
        i_row        <= row;
        i_char_code  <= ch;
        i_attribute  <= attr;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Hold off new words until every reply is in, then let the block settle.
    task automatic drain_replies();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (replies_due != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Setup cycle, then access cycle; the register takes the data at the
    // edge where psel, penable, pwrite and pready are all high, then idle
    // so the next write starts on a fresh edge.
    task automatic write_reg(input logic reg_idx, input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        // upper bits are junk; only the low byte is kept
        pwdata  <= ($urandom() & 32'hFFFF_FF00) | {24'h0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random word: mostly puts, with reads aimed at written cells, enough
    // bottom-row traffic to scroll, and a few clears, off-screen and unused codes.
    task automatic send_random_word();
        int         pick;
        int         place;
        logic [1:0] act;
        logic       at_cursor;
        logic [7:0] col;
        logic [7:0] row;
        logic [7:0] ch;
        logic [7:0] attr;
        pick      = $urandom_range(0, 99);
        place     = $urandom_range(0, 99);
        at_cursor = 1'b0;
        col       = 8'($urandom_range(0, COLUMNS - 1));
        row       = 8'($urandom_range(0, ROWS - 1));
        ch        = 8'($urandom_range(0, 255));
        attr      = 8'($urandom_range(0, 255));
        if (pick < 3) begin
            act = ACT_CLEAR;
        end else if (pick < 5) begin
            act       = ACT_UNUSED;
            at_cursor = 1'($urandom_range(0, 1));
            col       = 8'($urandom_range(0, 255));
            row       = 8'($urandom_range(0, 255));
        end else if (pick < 25) begin
            act = ACT_READ;
            if (place < 20) begin
                at_cursor = 1'b1;
            end else if (place < 60) begin
                col = last_col;
                row = last_row;
            end else if (place < 70) begin
                col = 8'($urandom_range(0, 255));
                row = 8'($urandom_range(0, 255));
            end
        end else begin
            act = ACT_PUT;
            if ($urandom_range(0, 9) == 0)
                ch = NEWLINE_CODE;
            if (place < 35) begin
                at_cursor = 1'b1;
            end else if (place < 45) begin
                // bottom row, near the last cell: scroll often
                row = 8'(ROWS - 1);
                col = 8'($urandom_range(COLUMNS - 4, COLUMNS - 1));
            end else if (place < 50) begin
                col = 8'($urandom_range(0, 255));
                row = 8'($urandom_range(0, 255));
            end
            if (!at_cursor) begin
                last_col = col;
                last_row = row;
            end
        end
        send_word(act, at_cursor, col, row, ch, attr);
    endtask

    initial begin
        // Hold reset first; the block then blanks the screen itself.
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words at reset register values, no idling.
        send_word(ACT_READ,   1'b1, 8'd0,  8'd0,  8'h00, 8'h00);  // blank cell after reset
        send_word(ACT_PUT,    1'b1, 8'd0,  8'd0,  8'h41, 8'h1F);
        send_word(ACT_PUT,    1'b1, 8'd0,  8'd0,  8'hFF, 8'hFF);
        send_word(ACT_PUT,    1'b1, 8'd0,  8'd0,  8'h00, 8'h00);
        send_word(ACT_PUT,    1'b1, 8'd0,  8'd0,  NEWLINE_CODE, 8'h00);
        send_word(ACT_PUT,    1'b0, 8'd0,  8'd0,  8'h5A, 8'hA5);
        send_word(ACT_READ,   1'b0, 8'd0,  8'd0,  8'h00, 8'h00);
        // last cell: wraps past the end and scrolls
        send_word(ACT_PUT,    1'b0, 8'(COLUMNS - 1), 8'(ROWS - 1), 8'h55, 8'h3C);
        send_word(ACT_READ,   1'b0, 8'(COLUMNS - 1), 8'(ROWS - 2), 8'h00, 8'h00);
        send_word(ACT_READ,   1'b0, 8'd0,  8'(ROWS - 1), 8'h00, 8'h00);
        // off-screen puts drop the marker in the last cell
        send_word(ACT_PUT,    1'b0, 8'(COLUMNS), 8'd0, 8'h31, 8'h11);
        send_word(ACT_READ,   1'b0, 8'(COLUMNS - 1), 8'(ROWS - 1), 8'h00, 8'h00);
        send_word(ACT_PUT,    1'b0, 8'd0,  8'(ROWS), 8'h32, 8'h22);
        send_word(ACT_PUT,    1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        // off-screen reads
        send_word(ACT_READ,   1'b0, 8'hFF, 8'd0,  8'h00, 8'h00);
        send_word(ACT_READ,   1'b0, 8'd0,  8'hFF, 8'h00, 8'h00);
        send_word(ACT_UNUSED, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        // newline on the bottom row scrolls, both at a cell and at the cursor
        send_word(ACT_PUT,    1'b0, 8'd5,  8'(ROWS - 1), NEWLINE_CODE, 8'h00);
        send_word(ACT_PUT,    1'b1, 8'd0,  8'd0,  NEWLINE_CODE, 8'h00);
        send_word(ACT_CLEAR,  1'b0, 8'd0,  8'd0,  8'h00, 8'h00);
        send_word(ACT_READ,   1'b1, 8'd0,  8'd0,  8'h00, 8'h00);
        // cursor on the last cell, then a put at the cursor scrolls
        send_word(ACT_PUT,    1'b0, 8'(COLUMNS - 2), 8'(ROWS - 1), 8'h61, 8'h70);
        send_word(ACT_PUT,    1'b1, 8'd0,  8'd0,  8'h62, 8'h71);
        send_word(ACT_READ,   1'b1, 8'd0,  8'd0,  8'h00, 8'h00);

        // Random phases; registers change only with no word in flight.
        for (int phase = 0; phase < PHASES; phase++) begin
            drain_replies();
            case (phase)
                0: begin
                    write_reg(REG_CLEAR_ATTR, 8'h00);
                    write_reg(REG_ERROR_ATTR, 8'hFF);
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    write_reg(REG_CLEAR_ATTR, 8'hFF);
                    write_reg(REG_ERROR_ATTR, 8'h00);
                    idle_pct  = 51;
                    stall_pct = 0;
                end
                2: begin
                    write_reg(REG_CLEAR_ATTR, 8'($urandom_range(0, 255)));
                    write_reg(REG_ERROR_ATTR, 8'($urandom_range(0, 255)));
                    idle_pct  = 0;
                    stall_pct = 51;
                end
                default: begin
                    write_reg(REG_CLEAR_ATTR, 8'($urandom_range(0, 255)));
                    write_reg(REG_ERROR_ATTR, 8'($urandom_range(0, 255)));
                    idle_pct  = 17;
                    stall_pct = 17;
                end
            endcase
            // start each phase from a cleared screen in the new attribute
            send_word(ACT_CLEAR, 1'b0, 8'd0, 8'd0, 8'h00, 8'h00);
            for (int n = 0; n < PHASE_WORDS; n++)
                send_random_word();
        end

        // Wait out the last replies, then give the verdict.
        drain_replies();
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
